// ----- src/twq_pkg.sv -----
// ----------------------------------------------------------------------------
// twq_pkg
// Shared types and constants for the tick delay wakeup queue: request codes,
// transaction structs and the control/status bundles of the cell chain.
// ----------------------------------------------------------------------------
package twq_pkg;

	localparam int KEY_W           = 32;
	localparam int TASK_W          = 5;
	localparam int REQ_W           = 2;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int MAX_RESULTS     = 32;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELAY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TIME  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_UNTIL = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [TASK_W-1:0] task_id;
		logic [KEY_W-1:0]  tick_count;
	} req_t;

	typedef struct packed {
		logic [TASK_W-1:0] reply_task;
		logic [KEY_W-1:0]  reply_time;
		logic              deadline_missed;
		logic              last_of_run;
	} rsp_t;

	// command to the cell chain
	typedef struct packed {
		logic              insert;
		logic              pop;
		logic [KEY_W-1:0]  key;
		logic [TASK_W-1:0] task_id;
	} chain_cmd_t;

	// status from the cell chain
	typedef struct packed {
		logic              head_valid;
		logic              next_valid;
		logic              full;
		logic [KEY_W-1:0]  head_key;
		logic [TASK_W-1:0] head_task;
		logic [KEY_W-1:0]  next_key;
	} chain_stat_t;

endpackage

// ----- src/twq_cell.sv -----
// ----------------------------------------------------------------------------
// twq_cell
// One slot of the sorted wakeup chain. Holds a wake key and a task id; on an
// insert it keeps, takes the new entry or takes its left neighbor, on a pop it
// takes its right neighbor.
// ----------------------------------------------------------------------------
module twq_cell (
	input  logic                             clk,
	input  twq_pkg::chain_cmd_t              cmd,
	input  logic                             occ,
	input  logic                             prev_gt,
	input  logic [twq_pkg::KEY_W-1:0]        prev_key,
	input  logic [twq_pkg::TASK_W-1:0]       prev_task,
	input  logic [twq_pkg::KEY_W-1:0]        next_key,
	input  logic [twq_pkg::TASK_W-1:0]       next_task,
	output logic                             gt,
	output logic [twq_pkg::KEY_W-1:0]        key,
	output logic [twq_pkg::TASK_W-1:0]       task_id
);
	import twq_pkg::*;

	logic [KEY_W-1:0]  key_q;
	logic [TASK_W-1:0] task_q;

	// entry belongs after the new key (empty slots count as after)
	assign gt = !occ || (key_q > cmd.key);

	// slot update: shift left on pop, open a gap on insert
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			key_q  <= next_key;
			task_q <= next_task;
		end else if (cmd.insert && gt) begin
			if (prev_gt) begin
				key_q  <= prev_key;
				task_q <= prev_task;
			end else begin
				key_q  <= cmd.key;
				task_q <= cmd.task_id;
			end
		end
	end

	assign key     = key_q;
	assign task_id = task_q;

endmodule

// ----- src/twq_chain.sv -----
// ----------------------------------------------------------------------------
// twq_chain
// Row of wakeup cells kept in ascending key order, ties in arrival order,
// plus the fill count that marks which cells are occupied.
// ----------------------------------------------------------------------------
module twq_chain #(
	parameter int QUEUE_DEPTH = twq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  twq_pkg::chain_cmd_t  cmd,
	output twq_pkg::chain_stat_t stat
);
	import twq_pkg::*;

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	logic [FILL_W-1:0] fill_q;
	logic              gt_w   [QUEUE_DEPTH];
	logic [KEY_W-1:0]  key_w  [QUEUE_DEPTH];
	logic [TASK_W-1:0] task_w [QUEUE_DEPTH];

	// cell row
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic              p_gt;
		logic [KEY_W-1:0]  p_key;
		logic [TASK_W-1:0] p_task;
		logic [KEY_W-1:0]  n_key;
		logic [TASK_W-1:0] n_task;

		if (i == 0) begin : g_first
			assign p_gt   = 1'b0;
			assign p_key  = '0;
			assign p_task = '0;
		end else begin : g_mid
			assign p_gt   = gt_w[i-1];
			assign p_key  = key_w[i-1];
			assign p_task = task_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign n_key  = '0;
			assign n_task = '0;
		end else begin : g_body
			assign n_key  = key_w[i+1];
			assign n_task = task_w[i+1];
		end

		twq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occ       (fill_q > FILL_W'(i)),
			.prev_gt   (p_gt),
			.prev_key  (p_key),
			.prev_task (p_task),
			.next_key  (n_key),
			.next_task (n_task),
			.gt        (gt_w[i]),
			.key       (key_w[i]),
			.task_id   (task_w[i])
		);
	end

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.insert && !cmd.pop) begin
			fill_q <= fill_q + FILL_W'(1);
		end else if (cmd.pop && !cmd.insert) begin
			fill_q <= fill_q - FILL_W'(1);
		end
	end

	// head view
	always_comb begin
		stat.head_valid = (fill_q != '0);
		stat.next_valid = (fill_q > FILL_W'(1));
		stat.full       = (fill_q == FILL_W'(QUEUE_DEPTH));
		stat.head_key   = key_w[0];
		stat.head_task  = task_w[0];
		stat.next_key   = key_w[1];
	end

	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !stat.full)
		else $error("insert issued into a full chain");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> stat.head_valid)
		else $error("pop issued on an empty chain");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("fill count beyond depth");

endmodule

// ----- src/tick_delay_wakeup_queue_core.sv -----
// ----------------------------------------------------------------------------
// tick_delay_wakeup_queue_core
// Tick counter with a sorted queue of sleeping tasks keyed by wake time.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries tick, delay, read-time and
//   delay-until transactions; rsp channel (rsp_valid/rsp_stall/rsp) returns
//   replies and wakeups, last_of_run set on the final one of each request.
//   One request is worked on at a time; req_stall is high while busy.
//   Read time and an immediate delay-until answer: the reply is registered
//   and visible the cycle after acceptance. Delay / delay-until that queue:
//   the insert state then does the sorted insert across the cell row in
//   parallel. Tick: advances the time, then the release state pops due tasks
//   (at most 32) one at a time from the head cell, each with a wakeup reply;
//   a tick that releases nothing returns to idle with no reply.
//   Inserts into a full queue are dropped with no reply.
//   Reset clears the time and the fill count; cell contents are don't-care.
//   When rsp_stall is high the reply register holds and the block waits,
//   taking no new request and releasing nothing until the reply is taken.
// ----------------------------------------------------------------------------
module tick_delay_wakeup_queue_core #(
	parameter int QUEUE_DEPTH = twq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  twq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output twq_pkg::rsp_t rsp
);
	import twq_pkg::*;

	localparam int CNT_W = $clog2(MAX_RESULTS);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_INSERT  = 2'd1;
	localparam logic [1:0] ST_RELEASE = 2'd2;

	logic [1:0]        state_q;
	logic [KEY_W-1:0]  tick_q;
	logic [KEY_W-1:0]  ins_key_q;
	logic [TASK_W-1:0] ins_task_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	chain_cmd_t  cmd;
	chain_stat_t stat;
	logic        out_free;
	logic        req_fire;
	logic        head_due;
	logic        next_due;
	logic        rel_last;
	logic        rsp_load;
	rsp_t        rsp_d;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) && out_free);
	assign req_fire  = req_valid && !req_stall;

	// release decision at the head of the chain
	assign head_due = stat.head_valid && (stat.head_key <= tick_q);
	assign next_due = stat.next_valid && (stat.next_key <= tick_q);
	assign rel_last = !next_due || (cnt_q == CNT_W'(MAX_RESULTS - 1));

	// chain command and reply selection
	always_comb begin
		cmd.insert  = (state_q == ST_INSERT) && !stat.full;
		cmd.pop     = (state_q == ST_RELEASE) && out_free && head_due;
		cmd.key     = ins_key_q;
		cmd.task_id = ins_task_q;

		rsp_load              = 1'b0;
		rsp_d.reply_task      = req.task_id;
		rsp_d.reply_time      = tick_q;
		rsp_d.deadline_missed = 1'b0;
		rsp_d.last_of_run     = 1'b1;
		if (state_q == ST_RELEASE) begin
			rsp_load          = cmd.pop;
			rsp_d.reply_task  = stat.head_task;
			rsp_d.last_of_run = rel_last;
		end else if (req_fire) begin
			case (req.req_type)
				REQ_TIME: rsp_load = 1'b1;
				REQ_UNTIL: begin
					rsp_load              = (req.tick_count <= tick_q);
					rsp_d.deadline_missed = (req.tick_count < tick_q);
				end
				default: rsp_load = 1'b0;
			endcase
		end
	end

	// sequencer, time counter and pending insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						unique case (req.req_type)
							REQ_TICK: begin
								tick_q  <= tick_q + KEY_W'(1);
								cnt_q   <= '0;
								state_q <= ST_RELEASE;
							end
							REQ_DELAY: state_q <= ST_INSERT;
							REQ_TIME:  state_q <= ST_IDLE;
							REQ_UNTIL: begin
								if (req.tick_count > tick_q) begin
									state_q <= ST_INSERT;
								end
							end
						endcase
					end
				end
				ST_INSERT: state_q <= ST_IDLE;
				ST_RELEASE: begin
					if (out_free) begin
						if (!head_due) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
							if (rel_last) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// insert key: relative delays add to the current time
	always_ff @(posedge clk) begin
		if (req_fire) begin
			ins_task_q <= req.task_id;
			if (req.req_type == REQ_DELAY) begin
				ins_key_q <= tick_q + req.tick_count;
			end else begin
				ins_key_q <= req.tick_count;
			end
		end
	end

	// reply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	twq_chain #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	a_tick_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.req_type == REQ_TICK) |=> tick_q == $past(tick_q) + KEY_W'(1))
		else $error("tick did not advance time by one");
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && rel_last) |=> state_q == ST_IDLE)
		else $error("release run continued after its last wakeup");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> out_free)
		else $error("reply loaded while the previous one is stalled");
	a_insert_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |=> (state_q == ST_IDLE && !cmd.insert))
		else $error("insert state lasted more than one cycle");

endmodule
